// ----- rtl/core/rms_edf_task_scheduler_tick_defines.svh -----
// Assertion macros shared by the scheduler RTL.
// In simulation they expand to labeled concurrent assertions.
// For synthesis they expand to nothing.
`ifndef RMS_EDF_TASK_SCHEDULER_TICK_DEFINES_SVH
`define RMS_EDF_TASK_SCHEDULER_TICK_DEFINES_SVH

`ifndef SYNTHESIS

`define RETS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`define RETS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define RETS_ASSERT(lbl, clk, rstn, prop, msg)

`define RETS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- rtl/core/rets_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rets_pkg;

  localparam int DATA_W  = 16;
  localparam int SLACK_W = 18;
  localparam int SLOT_W  = 3;
  localparam int NUM_W   = 4;
  localparam int CFG_W   = 4;

  // Configuration register indexes.
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  // Selection policies.
  localparam logic POLICY_RMS = 1'b0;
  localparam logic POLICY_EDF = 1'b1;

  // Input opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // write one task entry from the input ports
    logic tick_start;  // clear the running best candidate
    logic scan;        // release, compare and age the slot at the index
    logic finish;      // charge the winner and post the result
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/rets_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "rms_edf_task_scheduler_tick_defines.svh"

module rets_dp #(
  parameter int MAX_TASKS = 8,
  parameter int IDX_W     = 3,
  parameter int CNT_W     = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rets_pkg::cmd_t               cmd,
  input  wire logic [IDX_W-1:0]             idx,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [rets_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic [rets_pkg::SLOT_W-1:0]  in_task_slot,
  input  wire logic [rets_pkg::DATA_W-1:0]  in_exec_ticks,
  input  wire logic [rets_pkg::DATA_W-1:0]  in_period_ticks,
  input  wire logic [rets_pkg::DATA_W-1:0]  in_deadline_ticks,
  output logic [CNT_W-1:0]                  active_count,
  output logic                              out_strobe,
  output logic                              out_idle,
  output logic [rets_pkg::NUM_W-1:0]        out_task_number
);
  import rets_pkg::*;

  localparam logic signed [SLACK_W-1:0] SLACK_MIN = {1'b1, {(SLACK_W-1){1'b0}}};

  logic [DATA_W-1:0]         exec_table_r     [MAX_TASKS];
  logic [DATA_W-1:0]         period_table_r   [MAX_TASKS];
  logic [DATA_W-1:0]         deadline_table_r [MAX_TASKS];
  logic [DATA_W-1:0]         remaining_work_r [MAX_TASKS];
  logic [DATA_W-1:0]         phase_counter_r  [MAX_TASKS];
  logic signed [SLACK_W-1:0] deadline_slack_r [MAX_TASKS];

  logic              policy_r;
  logic [CFG_W-1:0]  count_r;

  logic                      found_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic [DATA_W-1:0]         best_per_r;
  logic signed [SLACK_W-1:0] best_slack_r;
  logic [DATA_W-1:0]         best_rem_r;

  logic              out_strobe_r;
  logic              out_idle_r;
  logic [NUM_W-1:0]  out_task_number_r;

  logic                      released;
  logic [DATA_W-1:0]         rem_eff;
  logic signed [SLACK_W-1:0] slack_eff;
  logic signed [SLACK_W-1:0] slack_nxt;
  logic [DATA_W:0]           phase_inc;
  logic [DATA_W-1:0]         phase_nxt;
  logic                      better;
  logic                      take;
  logic                      slot_ok;
  logic [IDX_W-1:0]          load_idx;
  logic [DATA_W-1:0]         period_clamped;

  always_comb begin
    if (int'(count_r) > MAX_TASKS) begin
      active_count = CNT_W'(MAX_TASKS);
    end else begin
      active_count = CNT_W'(count_r);
    end
  end

  // Per-slot work of one scan step: release, candidate compare and aging.
  always_comb begin
    released  = (phase_counter_r[idx] == '0);
    rem_eff   = released ? exec_table_r[idx] : remaining_work_r[idx];
    slack_eff = released ? $signed({2'b00, deadline_table_r[idx]}) : deadline_slack_r[idx];
    if (!found_r) begin
      better = 1'b1;
    end else if (policy_r == POLICY_EDF) begin
      better = slack_eff < best_slack_r;
    end else begin
      better = period_table_r[idx] < best_per_r;
    end
    take      = (rem_eff != '0) && better;
    slack_nxt = (slack_eff > SLACK_MIN) ? slack_eff - SLACK_W'(1) : slack_eff;
    phase_inc = {1'b0, phase_counter_r[idx]} + (DATA_W+1)'(1);
    phase_nxt = (phase_inc >= {1'b0, period_table_r[idx]}) ? '0 : phase_inc[DATA_W-1:0];
  end

  assign slot_ok        = int'(in_task_slot) < MAX_TASKS;
  assign load_idx       = IDX_W'(in_task_slot);
  assign period_clamped = (in_period_ticks == '0) ? DATA_W'(1) : in_period_ticks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        exec_table_r[i]     <= '0;
        period_table_r[i]   <= DATA_W'(1);
        deadline_table_r[i] <= '0;
        remaining_work_r[i] <= '0;
        phase_counter_r[i]  <= '0;
        deadline_slack_r[i] <= '0;
      end
    end else begin
      if (cmd.load && slot_ok) begin
        exec_table_r[load_idx]     <= in_exec_ticks;
        period_table_r[load_idx]   <= period_clamped;
        deadline_table_r[load_idx] <= in_deadline_ticks;
        phase_counter_r[load_idx]  <= '0;
        remaining_work_r[load_idx] <= '0;
      end
      if (cmd.scan) begin
        remaining_work_r[idx] <= rem_eff;
        deadline_slack_r[idx] <= slack_nxt;
        phase_counter_r[idx]  <= phase_nxt;
      end
      if (cmd.finish && found_r) begin
        remaining_work_r[best_idx_r] <= best_rem_r - DATA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_RMS;
      count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLICY: policy_r <= cfg_data[0];
        REG_COUNT:  count_r  <= cfg_data;
        default:    count_r  <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.tick_start) begin
      found_r <= 1'b0;
    end else if (cmd.scan && take) begin
      found_r <= 1'b1;
    end
  end

  // The best candidate keeps its pre-aging slack so every slot is compared
  // against values from the same point in the tick.
  always_ff @(posedge clk) begin
    if (cmd.scan && take) begin
      best_idx_r   <= idx;
      best_per_r   <= period_table_r[idx];
      best_slack_r <= slack_eff;
      best_rem_r   <= rem_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.load || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_idle_r        <= 1'b1;
      out_task_number_r <= '0;
    end else if (cmd.finish) begin
      out_idle_r        <= !found_r;
      out_task_number_r <= found_r ? NUM_W'(int'(best_idx_r) + 1) : '0;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_idle        = out_idle_r;
  assign out_task_number = out_task_number_r;

  `RETS_ASSERT(a_winner_in_range, clk, rst_n, cmd.finish && found_r |-> int'(best_idx_r) < int'(active_count), "winner slot outside the active range")
  `RETS_ASSERT(a_run_has_number, clk, rst_n, out_strobe_r && !out_idle_r |-> out_task_number_r != '0, "running result carries no task number")

endmodule

`default_nettype wire

// ----- rtl/core/rets_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "rms_edf_task_scheduler_tick_defines.svh"

module rets_ctrl #(
  parameter int IDX_W = 3,
  parameter int CNT_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_opcode,
  input  wire logic [CNT_W-1:0]  active_count,
  output rets_pkg::cmd_t         cmd,
  output logic [IDX_W-1:0]       idx,
  output logic                   busy
);
  import rets_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  idx_nxt;
  logic              accept;
  logic              last_slot;

  assign accept    = start && (state_r == ST_IDLE);
  assign last_slot = (int'(idx_r) + 1) >= int'(active_count);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_opcode == OP_TICK) begin
          idx_nxt   = '0;
          state_nxt = (active_count == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_slot) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    cmd.load       = accept && (in_opcode == OP_LOAD);
    cmd.tick_start = accept && (in_opcode == OP_TICK);
    cmd.scan       = (state_r == ST_SCAN);
    cmd.finish     = (state_r == ST_FINISH);
  end

  assign idx  = idx_r[IDX_W-1:0];
  assign busy = (state_r != ST_IDLE);

  `RETS_ASSERT(a_tick_goes_busy, clk, rst_n, cmd.tick_start |=> busy, "accepted tick did not start a scan")
  `RETS_ASSERT(a_finish_frees, clk, rst_n, cmd.finish |=> !busy, "controller stayed busy after finish")
  `RETS_ASSERT(a_scan_in_range, clk, rst_n, cmd.scan |-> int'(idx_r) < int'(active_count), "scan index beyond the active slots")
  `RETS_ASSERT_NEVER(a_load_exclusive, clk, rst_n, cmd.load && (cmd.scan || cmd.finish), "load overlaps a tick in progress")

endmodule

`default_nettype wire

// ----- rtl/core/rms_edf_task_scheduler_tick.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Periodic-task scheduler, one time tick or one task load per transaction.
// Input: a transaction is taken at a clock edge with start high and busy low.
// A load (opcode 1) writes one task slot in that same edge; a tick (opcode 0)
// releases due tasks, picks one ready task by period (rate monotonic) or by
// slack (earliest deadline first) and charges it one tick of work.
// Output: every transaction yields one result, shown for exactly one cycle
// with out_strobe high. The receiver cannot stall; it must take each result.
// Timing: a load answers in the cycle after it is taken and busy stays low,
// so loads can be issued every cycle. A tick walks the active slots one per
// cycle through a single shared compare unit, then charges the winner in the
// finish state: busy stays high through scan and finish, and the result
// is registered from the finish state; at most MAX_TASKS slots are active.
// A new tick can start in the cycle its result is shown.
// Configuration: cfg_index 0 selects the policy, 1 the active task count.
// cfg_ready is low while a tick is in progress and while start is high.
// Reset: synchronous, active low; all task tables return to their defaults
// (period 1, everything else 0) and both registers to 0. No clearing pass.

module rms_edf_task_scheduler_tick #(
  parameter int MAX_TASKS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_opcode,
  input  wire logic [rets_pkg::SLOT_W-1:0]  in_task_slot,
  input  wire logic [rets_pkg::DATA_W-1:0]  in_exec_ticks,
  input  wire logic [rets_pkg::DATA_W-1:0]  in_period_ticks,
  input  wire logic [rets_pkg::DATA_W-1:0]  in_deadline_ticks,
  output logic                              out_strobe,
  output logic                              out_idle,
  output logic [rets_pkg::NUM_W-1:0]        out_task_number,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [rets_pkg::CFG_W-1:0]   cfg_data
);
  import rets_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  cmd_t              cmd;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  active_count;
  logic              cfg_we;

  // A register write never shares an edge with an input transaction.
  assign cfg_ready = !busy && !start;
  assign cfg_we    = cfg_valid && cfg_ready;

  rets_ctrl #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_opcode    (in_opcode),
    .active_count (active_count),
    .cmd          (cmd),
    .idx          (idx),
    .busy         (busy)
  );

  rets_dp #(
    .MAX_TASKS (MAX_TASKS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .idx               (idx),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_task_slot      (in_task_slot),
    .in_exec_ticks     (in_exec_ticks),
    .in_period_ticks   (in_period_ticks),
    .in_deadline_ticks (in_deadline_ticks),
    .active_count      (active_count),
    .out_strobe        (out_strobe),
    .out_idle          (out_idle),
    .out_task_number   (out_task_number)
  );

endmodule

`default_nettype wire
